>>> hdl/rcfr_pkg.sv
// shared types and constants for the bus command frame receiver
package rcfr_pkg;

  localparam int FRAME_LEN = 7;
  localparam int IDX_W     = $clog2(FRAME_LEN);
  localparam int CNT_W     = $clog2(FRAME_LEN + 1);

  localparam logic [7:0] START_MARK      = 8'h99;
  localparam logic [7:0] CHECK_SEED      = 8'h55;
  localparam logic [7:0] ADDR_RESET      = 8'h11;
  localparam logic [6:0] SIZE_MASK       = 7'h7f;
  localparam logic [6:0] SIZE_ONE        = 7'h01;
  localparam logic [7:0] CMD_LED_ON      = 8'hc1;
  localparam logic [7:0] CMD_LED_OFF     = 8'hc2;
  localparam logic [7:0] CMD_RELAY_FIRST = 8'hc3;
  localparam logic [7:0] CMD_RELAY_LAST  = 8'hca;

  // byte positions inside a frame
  localparam logic [IDX_W-1:0] POS_START = IDX_W'(0);
  localparam logic [IDX_W-1:0] POS_DEST  = IDX_W'(1);
  localparam logic [IDX_W-1:0] POS_SRC   = IDX_W'(2);
  localparam logic [IDX_W-1:0] POS_MODE  = IDX_W'(3);
  localparam logic [IDX_W-1:0] POS_HCHK  = IDX_W'(4);
  localparam logic [IDX_W-1:0] POS_CMD   = IDX_W'(5);
  localparam logic [IDX_W-1:0] POS_DCHK  = IDX_W'(6);
  localparam logic [IDX_W-1:0] POS_LAST  = IDX_W'(FRAME_LEN - 1);

  typedef enum logic [2:0] {
    STAT_COLLECT    = 3'd0,
    STAT_ACCEPT     = 3'd1,
    STAT_BAD_START  = 3'd2,
    STAT_WRONG_ADDR = 3'd3,
    STAT_READ       = 3'd4,
    STAT_HEADER     = 3'd5,
    STAT_SIZE       = 3'd6,
    STAT_DATA       = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    OPD_START = 2'd0,
    OPD_ADDR  = 2'd1,
    OPD_ACC   = 2'd2
  } operand_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_INIT = 2'd1,
    ACC_XOR  = 2'd2
  } acc_op_t;

  typedef struct packed {
    operand_sel_t opd;
    acc_op_t      acc_op;
  } unit_ctrl_t;

endpackage

>>> hdl/rcfr_if.sv
// request channels: received bytes in, frame results out
interface rcfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface rcfr_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] command;
  logic       led_on;
  logic [3:0] relays;
  modport source (output valid, output status, output command, output led_on,
                  output relays, input ready);
  modport sink (input valid, input status, input command, input led_on,
                input relays, output ready);
endinterface

>>> hdl/rcfr_check_unit.sv
// shared xor compare unit with running check accumulator
module rcfr_check_unit (
  input  logic                 clk,
  input  rcfr_pkg::unit_ctrl_t ctrl,
  input  logic [7:0]           byte_in,
  input  logic [7:0]           address,
  output logic                 match
);
  import rcfr_pkg::*;

  logic [7:0] acc;
  logic [7:0] operand;

  always_comb begin
    unique case (ctrl.opd)
      OPD_START: operand = START_MARK;
      OPD_ADDR:  operand = address;
      OPD_ACC:   operand = acc;
      default:   operand = acc;
    endcase
  end

  assign match = ((operand ^ byte_in) == 8'h00);

  always_ff @(posedge clk) begin
    unique case (ctrl.acc_op)
      ACC_INIT: acc <= CHECK_SEED ^ byte_in;
      ACC_XOR:  acc <= acc ^ byte_in;
      default:  acc <= acc;
    endcase
  end

endmodule

>>> hdl/rcfr_actuator.sv
// led and relay output registers driven by accepted commands
module rcfr_actuator (
  input  logic       clk,
  input  logic       rst,
  input  logic       exec_en,
  input  logic [7:0] cmd,
  output logic       led_on,
  output logic [3:0] relays
);
  import rcfr_pkg::*;

  logic [3:0] offset;
  logic       in_relay_range;

  assign offset         = cmd[3:0] - CMD_RELAY_FIRST[3:0];
  assign in_relay_range = (cmd >= CMD_RELAY_FIRST) && (cmd <= CMD_RELAY_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      led_on <= 1'b0;
      relays <= 4'b0000;
    end else if (exec_en) begin
      priority if (cmd == CMD_LED_ON) begin
        led_on <= 1'b1;
      end else if (cmd == CMD_LED_OFF) begin
        led_on <= 1'b0;
      end else if (in_relay_range) begin
        // even offset clears, odd offset sets
        relays[offset[2:1]] <= offset[0];
      end
    end
  end

endmodule

>>> hdl/rs485_command_frame_receiver.sv
// top level: frame store, check sequencer and result register
//
//   channel | dir | fields                             | handshake
//   rx      | in  | rx_byte                            | valid/ready
//   result  | out | status, command, led_on, relays    | valid/ready
//   cfg     | in  | cfg_wdata (device address)         | cfg_we
//
// a byte that does not complete a frame passes from idle straight to done
// a byte that completes a frame is checked in check; a failed check adds a scan for
// the next start byte and, if one is found, a shift that realigns the held bytes; the
// check and scan use the single compare unit, reading one stored byte per cycle
// rx is taken only in idle; a result still waiting on result.ready holds the next
// request in done until the output register frees
// synchronous reset empties the frame, clears led and relays, address back to 0x11
module rs485_command_frame_receiver (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_wdata,
  rcfr_rx_if.sink          rx,
  rcfr_res_if.source       result
);
  import rcfr_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_SCAN  = 5'b00100,
    S_SHIFT = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t           state;
  logic [7:0]       device_address;
  logic [7:0]       frame [FRAME_LEN];
  logic [CNT_W-1:0] fill;
  logic [IDX_W-1:0] step;
  logic [IDX_W-1:0] shift_amt;
  logic [IDX_W-1:0] dst;
  logic [IDX_W-1:0] rd_idx;
  logic [7:0]       rd_byte;
  logic             size_ok;
  logic [7:0]       cmd_hold;
  status_t          stat;
  logic [7:0]       cmd_out;
  logic             exec_en;
  logic             match;
  logic             accept;
  logic             out_free;
  logic             res_load;
  unit_ctrl_t       ctrl;
  logic             led_state;
  logic [3:0]       relay_state;

  assign rx.ready = (state == S_IDLE);
  assign accept   = rx.valid && rx.ready;
  assign out_free = !result.valid || result.ready;
  assign res_load = (state == S_DONE) && out_free;

  always_comb begin
    unique case (state)
      S_SHIFT: rd_idx = dst + shift_amt;
      default: rd_idx = step;
    endcase
  end

  assign rd_byte = frame[rd_idx];

  always_comb begin
    ctrl.opd    = OPD_START;
    ctrl.acc_op = ACC_HOLD;
    if (state == S_CHECK) begin
      unique case (step)
        POS_START: begin ctrl.opd = OPD_START; ctrl.acc_op = ACC_INIT; end
        POS_DEST:  begin ctrl.opd = OPD_ADDR;  ctrl.acc_op = ACC_XOR;  end
        POS_SRC:   ctrl.acc_op = ACC_XOR;
        POS_MODE:  ctrl.acc_op = ACC_XOR;
        POS_HCHK:  ctrl.opd = OPD_ACC;
        POS_CMD:   ctrl.acc_op = ACC_INIT;
        POS_DCHK:  ctrl.opd = OPD_ACC;
        default:   ctrl.acc_op = ACC_HOLD;
      endcase
    end
  end

  rcfr_check_unit u_check (
    .clk     (clk),
    .ctrl    (ctrl),
    .byte_in (rd_byte),
    .address (device_address),
    .match   (match)
  );

  assign exec_en = (state == S_CHECK) && (step == POS_DCHK) && match;

  rcfr_actuator u_act (
    .clk     (clk),
    .rst     (rst),
    .exec_en (exec_en),
    .cmd     (cmd_hold),
    .led_on  (led_state),
    .relays  (relay_state)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= ADDR_RESET;
    end else if (cfg_we) begin
      device_address <= cfg_wdata;
    end
  end

  // frame store writes: incoming byte or realign copy
  always_ff @(posedge clk) begin
    if (accept) begin
      frame[fill[IDX_W-1:0]] <= rx.rx_byte;
    end else if (state == S_SHIFT) begin
      frame[dst] <= rd_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      fill         <= '0;
      step         <= '0;
      shift_amt    <= '0;
      dst          <= '0;
      result.valid <= 1'b0;
    end else begin
      if (res_load) begin
        result.valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            fill    <= fill + CNT_W'(1);
            cmd_out <= 8'h00;
            stat    <= STAT_COLLECT;
            step    <= POS_START;
            if (fill == CNT_W'(FRAME_LEN - 1)) begin
              state <= S_CHECK;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_CHECK: begin
          unique case (step)
            POS_START: begin
              if (!match) begin
                stat  <= STAT_BAD_START;
                step  <= POS_DEST;
                state <= S_SCAN;
              end else begin
                step <= step + IDX_W'(1);
              end
            end
            POS_DEST: begin
              if (!match) begin
                stat  <= STAT_WRONG_ADDR;
                step  <= POS_DEST;
                state <= S_SCAN;
              end else begin
                step <= step + IDX_W'(1);
              end
            end
            POS_SRC: begin
              step <= step + IDX_W'(1);
            end
            POS_MODE: begin
              size_ok <= ((rd_byte[6:0] & SIZE_MASK) == SIZE_ONE);
              if (rd_byte[7]) begin
                stat  <= STAT_READ;
                step  <= POS_DEST;
                state <= S_SCAN;
              end else begin
                step <= step + IDX_W'(1);
              end
            end
            POS_HCHK: begin
              if (!match || !size_ok) begin
                stat  <= match ? STAT_SIZE : STAT_HEADER;
                step  <= POS_DEST;
                state <= S_SCAN;
              end else begin
                step <= step + IDX_W'(1);
              end
            end
            POS_CMD: begin
              cmd_hold <= rd_byte;
              step     <= step + IDX_W'(1);
            end
            POS_DCHK: begin
              if (!match) begin
                stat  <= STAT_DATA;
                step  <= POS_DEST;
                state <= S_SCAN;
              end else begin
                stat    <= STAT_ACCEPT;
                cmd_out <= cmd_hold;
                fill    <= '0;
                state   <= S_DONE;
              end
            end
            default: ;
          endcase
        end
        S_SCAN: begin
          // look for the next start byte still held
          if (match) begin
            shift_amt <= step;
            dst       <= '0;
            state     <= S_SHIFT;
          end else if (step == POS_LAST) begin
            fill  <= '0;
            state <= S_DONE;
          end else begin
            step <= step + IDX_W'(1);
          end
        end
        S_SHIFT: begin
          if (dst == POS_LAST - shift_amt) begin
            fill  <= CNT_W'(FRAME_LEN) - CNT_W'(shift_amt);
            state <= S_DONE;
          end else begin
            dst <= dst + IDX_W'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            result.status  <= stat;
            result.command <= cmd_out;
            result.led_on  <= led_state;
            result.relays  <= relay_state;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
